// ===== rtl/sces_pkg.sv =====
`timescale 1ns / 1ps

package sces_pkg;

    // default build widths
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF  = 16;

    // fixed field widths
    localparam int TS_W    = 32;
    localparam int SPEED_W = 24;
    localparam int CONV_W  = 8;
    localparam int POLL_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_CONV    = 1'b1;

    // register reset values
    localparam logic [POLL_W-1:0] POLL_INTERVAL_RST = 16'd250;
    localparam logic [CONV_W-1:0] STEPS_CONV_RST    = 8'd33;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 24'hFF_FFFF;

    // control from the sequencer to the calibration front end
    typedef struct packed {
        logic step;
        logic use_sample;
        logic clear_count;
    } sces_calib_ctrl_t;

    // trigger status back to the sequencer
    typedef struct packed {
        logic level;
        logic rising;
    } sces_calib_flags_t;

endpackage

// ===== rtl/sces_if.sv =====
`timescale 1ns / 1ps

interface sces_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [SAMPLE_BITS-1:0] sample;
    logic [31:0]            timestamp;

    modport source (output valid, func, sample, timestamp, input ready);
    modport sink   (input valid, func, sample, timestamp, output ready);
endinterface

interface sces_out_if #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
);
    logic                   valid;
    logic                   ready;
    logic                   level_high;
    logic                   rising_edge;
    logic [COUNT_BITS-1:0]  edge_count;
    logic [23:0]            speed;
    logic                   speed_updated;
    logic [SAMPLE_BITS-1:0] min_seen;
    logic [SAMPLE_BITS-1:0] max_seen;

    modport source (output valid, level_high, rising_edge, edge_count, speed,
                    speed_updated, min_seen, max_seen, input ready);
    modport sink   (input valid, level_high, rising_edge, edge_count, speed,
                    speed_updated, min_seen, max_seen, output ready);
endinterface

// ===== rtl/self_calibrating_encoder_speed_top.sv =====
`timescale 1ns / 1ps

// channel  | modport | role                                   | transaction when
// ---------+---------+----------------------------------------+-------------------
// in_ch    | sink    | func, sample, timestamp                | valid && ready
// out_ch   | source  | level, edge, count, speed, range       | valid && ready
// cfg      | write   | cfg_we / cfg_index / cfg_data          | cfg_we high
//
// one item at a time: accept, the elapsed-time test, then the result is
// loaded into the output register. when the poll interval has passed, the
// serial speed unit comes in between: shift-add for the product, restoring
// division, saturation and its registered done flag, in that order.
// rst_n is asynchronous and returns the calibration to mid-scale.
// a stalled output only holds the sequencer once the next result is ready.
module self_calibrating_encoder_speed_top
    import sces_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sces_in_if.sink              in_ch,
    sces_out_if.source           out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_CALC = 4'b0100,
        ST_OUT  = 4'b1000
    } st_t;

    st_t                    state_reg, state_next;

    // configuration registers
    logic [POLL_W-1:0]      poll_reg;
    logic [CONV_W-1:0]      conv_reg;

    // timing state
    logic [TS_W-1:0]        now_reg, now_next;
    logic [TS_W-1:0]        last_poll_reg, last_poll_next;
    logic                   upd_reg, upd_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_level_reg, out_rising_reg, out_upd_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;
    logic [SPEED_W-1:0]     out_speed_reg;
    logic [SAMPLE_BITS-1:0] out_min_reg, out_max_reg;

    logic                   in_acc;
    logic                   out_load;
    logic [TS_W-1:0]        elapsed;
    logic                   interval_passed;
    logic                   spd_start;
    logic                   spd_done;
    logic [SPEED_W-1:0]     spd_speed;

    sces_calib_ctrl_t       cal_ctrl;
    sces_calib_flags_t      cal_flags;
    logic [COUNT_BITS-1:0]  cal_count;
    logic [SAMPLE_BITS-1:0] cal_min, cal_max;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;

    // elapsed time wraps modulo 2^32
    assign elapsed         = now_reg - last_poll_reg;
    assign interval_passed = elapsed > {{(TS_W - POLL_W){1'b0}}, poll_reg};
    assign spd_start       = (state_reg == ST_EVAL) && interval_passed;

    // output register loads when empty or being drained
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    assign cal_ctrl.step        = in_acc;
    assign cal_ctrl.use_sample  = in_ch.func;
    assign cal_ctrl.clear_count = spd_start;

    sces_calib #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_calib (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cal_ctrl),
        .sample   (in_ch.sample),
        .flags    (cal_flags),
        .count    (cal_count),
        .min_seen (cal_min),
        .max_seen (cal_max)
    );

    // count captured at start, before the clear lands
    sces_speed #(
        .COUNT_BITS (COUNT_BITS)
    ) u_speed (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (spd_start),
        .count   (cal_count),
        .conv    (conv_reg),
        .divisor (elapsed),
        .done    (spd_done),
        .speed   (spd_speed)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        last_poll_next = last_poll_reg;
        upd_next       = upd_reg;
        out_valid_next = out_valid_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    now_next   = in_ch.timestamp;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                upd_next = interval_passed;
                if (interval_passed)
                begin
                    last_poll_next = now_reg;
                    state_next     = ST_CALC;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_CALC:
            begin
                if (spd_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_poll_reg <= '0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            poll_reg      <= POLL_INTERVAL_RST;
            conv_reg      <= STEPS_CONV_RST;
        end
        else
        begin
            state_reg     <= state_next;
            last_poll_reg <= last_poll_next;
            upd_reg       <= upd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POLL_INTERVAL: poll_reg <= cfg_data[POLL_W-1:0];
                    REG_STEPS_CONV:    conv_reg <= cfg_data[CONV_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        if (out_load)
        begin
            out_level_reg  <= cal_flags.level;
            out_rising_reg <= cal_flags.rising;
            out_count_reg  <= cal_count;
            out_speed_reg  <= spd_speed;
            out_upd_reg    <= upd_reg;
            out_min_reg    <= cal_min;
            out_max_reg    <= cal_max;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.level_high    = out_level_reg;
    assign out_ch.rising_edge   = out_rising_reg;
    assign out_ch.edge_count    = out_count_reg;
    assign out_ch.speed         = out_speed_reg;
    assign out_ch.speed_updated = out_upd_reg;
    assign out_ch.min_seen      = out_min_reg;
    assign out_ch.max_seen      = out_max_reg;

    // the speed unit only finishes while the sequencer waits on it
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        spd_done |-> (state_reg == ST_CALC))
        else $error("speed unit finished outside the calculation phase");

    // a speed update always reports a cleared edge count
    a_clear_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && upd_reg) |=> (out_ch.edge_count == '0))
        else $error("edge count not cleared on speed update");

    // an accepted transaction goes straight to the elapsed-time test
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_EVAL))
        else $error("sequencer skipped the elapsed-time test");

endmodule

// ===== rtl/sces_calib.sv =====
`timescale 1ns / 1ps

module sces_calib
    import sces_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sces_calib_ctrl_t       ctrl,
    input  logic [SAMPLE_BITS-1:0] sample,
    output sces_calib_flags_t      flags,
    output logic [COUNT_BITS-1:0]  count,
    output logic [SAMPLE_BITS-1:0] min_seen,
    output logic [SAMPLE_BITS-1:0] max_seen
);

    localparam logic [SAMPLE_BITS-1:0] MID_RST  = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] HYST_RST = SAMPLE_BITS'(1) << (SAMPLE_BITS - 3);

    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] mid_reg, mid_next;
    logic [SAMPLE_BITS-1:0] hyst_reg, hyst_next;
    logic                   level_reg, level_next;
    logic                   rising_reg, rising_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    logic                   shift;
    logic [SAMPLE_BITS:0]   span_sum;
    logic [SAMPLE_BITS-1:0] mid_calc, hyst_calc, mid_use, hyst_use;
    logic [SAMPLE_BITS:0]   hi_th, low_sum;
    logic                   above, below, lvl_new, rise;

    always_comb
    begin
        max_next    = max_reg;
        min_next    = min_reg;
        mid_next    = mid_reg;
        hyst_next   = hyst_reg;
        level_next  = level_reg;
        rising_next = rising_reg;
        count_next  = count_reg;

        // widen the running range
        shift    = (sample > max_reg) || (sample < min_reg);
        span_sum = {1'b0, (sample < min_reg) ? sample : min_reg}
                 + {1'b0, (sample > max_reg) ? sample : max_reg};
        mid_calc = span_sum[SAMPLE_BITS:1];
        if (((sample > max_reg) ? sample : max_reg) >= mid_calc)
        begin
            hyst_calc = SAMPLE_BITS'((((sample > max_reg) ? sample : max_reg)
                                      - mid_calc) >> 1);
        end
        else
        begin
            hyst_calc = '0;
        end
        mid_use  = shift ? mid_calc  : mid_reg;
        hyst_use = shift ? hyst_calc : hyst_reg;

        // schmitt thresholds, kept unsigned by moving hyst across
        hi_th   = {1'b0, mid_use} + {1'b0, hyst_use};
        low_sum = {1'b0, sample} + {1'b0, hyst_use};
        above   = {1'b0, sample} > hi_th;
        below   = low_sum < {1'b0, mid_use};
        lvl_new = below ? 1'b0 : (above ? 1'b1 : level_reg);
        rise    = lvl_new && !level_reg;

        if (ctrl.step)
        begin
            rising_next = 1'b0;
            if (ctrl.use_sample)
            begin
                max_next    = (sample > max_reg) ? sample : max_reg;
                min_next    = (sample < min_reg) ? sample : min_reg;
                mid_next    = mid_use;
                hyst_next   = hyst_use;
                level_next  = lvl_new;
                rising_next = rise;
                if (rise && (count_reg != {COUNT_BITS{1'b1}}))
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
        end
        if (ctrl.clear_count)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= '0;
            min_reg    <= '1;
            mid_reg    <= MID_RST;
            hyst_reg   <= HYST_RST;
            level_reg  <= 1'b0;
            rising_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            max_reg    <= max_next;
            min_reg    <= min_next;
            mid_reg    <= mid_next;
            hyst_reg   <= hyst_next;
            level_reg  <= level_next;
            rising_reg <= rising_next;
            count_reg  <= count_next;
        end
    end

    assign flags.level  = level_reg;
    assign flags.rising = rising_reg;
    assign count        = count_reg;
    assign min_seen     = min_reg;
    assign max_seen     = max_reg;

endmodule

// ===== rtl/sces_speed.sv =====
`timescale 1ns / 1ps

module sces_speed
    import sces_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [CONV_W-1:0]     conv,
    input  logic [TS_W-1:0]       divisor,
    output logic                  done,
    output logic [SPEED_W-1:0]    speed
);

    localparam int PW     = COUNT_BITS + CONV_W;
    localparam int STEP_W = $clog2(PW + 1);
    localparam logic [PW+SPEED_W-1:0] SAT_LIM = (PW + SPEED_W)'(SPEED_MAX);

    typedef enum logic [3:0] {
        SP_IDLE = 4'b0001,
        SP_MUL  = 4'b0010,
        SP_DIV  = 4'b0100,
        SP_SAT  = 4'b1000
    } sp_state_t;

    sp_state_t             state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CONV_W-1:0]     conv_reg, conv_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [TS_W-1:0]       div_reg, div_next;
    logic [TS_W-1:0]       rem_reg, rem_next;
    logic [PW-1:0]         dq_reg, dq_next;
    logic [SPEED_W-1:0]    speed_reg, speed_next;
    logic                  done_reg, done_next;

    logic [TS_W:0]         rem_sh, rem_sub;
    logic                  ge;
    logic [PW+SPEED_W-1:0] q_ext;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        conv_next  = conv_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        speed_next = speed_reg;
        done_next  = 1'b0;

        // one restoring division digit
        rem_sh  = {rem_reg, dq_reg[PW-1]};
        rem_sub = rem_sh - {1'b0, div_reg};
        ge      = rem_sh >= {1'b0, div_reg};
        q_ext   = {{SPEED_W{1'b0}}, dq_reg};

        case (state_reg)
            SP_IDLE:
            begin
                if (start)
                begin
                    conv_next  = conv;
                    cnt_next   = count;
                    div_next   = divisor;
                    rem_next   = '0;
                    dq_next    = '0;
                    step_next  = '0;
                    state_next = SP_MUL;
                end
            end
            SP_MUL:
            begin
                // shift-add, conversion factor msb first
                dq_next   = {dq_reg[PW-2:0], 1'b0}
                          + (conv_reg[CONV_W-1] ? {{CONV_W{1'b0}}, cnt_reg} : {PW{1'b0}});
                conv_next = {conv_reg[CONV_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CONV_W - 1))
                begin
                    step_next  = '0;
                    state_next = SP_DIV;
                end
            end
            SP_DIV:
            begin
                rem_next  = ge ? rem_sub[TS_W-1:0] : rem_sh[TS_W-1:0];
                dq_next   = {dq_reg[PW-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(PW - 1))
                begin
                    state_next = SP_SAT;
                end
            end
            SP_SAT:
            begin
                speed_next = (q_ext > SAT_LIM) ? SPEED_MAX : dq_reg[SPEED_W-1:0];
                done_next  = 1'b1;
                state_next = SP_IDLE;
            end
            default:
            begin
                state_next = SP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SP_IDLE;
            step_reg  <= '0;
            speed_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            speed_reg <= speed_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_reg <= conv_next;
        cnt_reg  <= cnt_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
    end

    assign done  = done_reg;
    assign speed = speed_reg;

endmodule

// ===== verif/sces_tb_pkg.sv =====
`timescale 1ns / 1ps

package sces_tb_pkg;

    import sces_pkg::*;

    // item kind carried in the func field
    typedef enum logic {
        FN_POLL   = 1'b0,
        FN_SAMPLE = 1'b1
    } func_e;

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int SAMPLE_MID = 1 << (SAMPLE_BITS_DEF - 1);

endpackage

// ===== verif/sces_speed_check.sv =====
`timescale 1ns / 1ps

module sces_speed_check
    import sces_pkg::*;
    import sces_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    sces_in_if                   in_ch,
    sces_out_if                  out_ch,
    output int                   mismatches,
    output int                   readings_checked,
    output int                   speed_updates,
    output int                   rising_edges
);

    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic                       level_high;
        logic                       rising_edge;
        logic [COUNT_BITS_DEF-1:0]  edge_count;
        logic [SPEED_W-1:0]         speed;
        logic                       speed_updated;
        logic [SAMPLE_BITS_DEF-1:0] min_seen;
        logic [SAMPLE_BITS_DEF-1:0] max_seen;
    } reading_t;

    reading_t readings_due[$];

    // register copies
    logic [POLL_W-1:0] poll_ms;
    logic [CONV_W-1:0] conv;

    // calibration, trigger and speed state
    logic [SAMPLE_BITS_DEF-1:0] lo_seen;
    logic [SAMPLE_BITS_DEF-1:0] hi_seen;
    logic [SAMPLE_BITS_DEF-1:0] midpoint;
    logic [SAMPLE_BITS_DEF-1:0] hyst;
    logic                       level;
    logic [COUNT_BITS_DEF-1:0]  edges;
    logic [TS_W-1:0]            last_poll_ms;
    logic [SPEED_W-1:0]         speed_now;

    int mismatch_count;
    int checked;
    int update_count;
    int edge_total;

    function automatic reading_t step_encoder(func_e fn, logic [SAMPLE_BITS_DEF-1:0] s,
                                              logic [TS_W-1:0] ts);
        reading_t         r;
        logic             was_high;
        logic             moved;
        int               hi_th;
        int               lo_th;
        logic [TS_W-1:0]  elapsed;
        longint unsigned  prod;
        longint unsigned  quot;
        r.rising_edge   = 1'b0;
        r.speed_updated = 1'b0;
        if (fn == FN_SAMPLE)
        begin
            was_high = level;
            moved    = 1'b0;
            if (s > hi_seen)
            begin
                hi_seen = s;
                moved   = 1'b1;
            end
            if (s < lo_seen)
            begin
                lo_seen = s;
                moved   = 1'b1;
            end
            if (moved)
            begin
                midpoint = SAMPLE_BITS_DEF'((int'(lo_seen) + int'(hi_seen)) / 2);
                hyst     = (hi_seen >= midpoint) ? (hi_seen - midpoint) >> 1 : '0;
            end
            hi_th = int'(midpoint) + int'(hyst);
            lo_th = int'(midpoint) - int'(hyst);
            if (int'(s) > hi_th)
                level = 1'b1;
            if (int'(s) < lo_th)
                level = 1'b0;
            if (level && !was_high)
            begin
                r.rising_edge = 1'b1;
                if (edges != '1)
                    edges = edges + 1'b1;
            end
        end
        // elapsed time wraps, so a step back in time reads as a long wait
        elapsed = ts - last_poll_ms;
        if (elapsed > TS_W'(poll_ms))
        begin
            prod            = 64'(edges) * 64'(conv);
            quot            = prod / 64'(elapsed);
            speed_now       = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(quot);
            edges           = '0;
            last_poll_ms    = ts;
            r.speed_updated = 1'b1;
        end
        r.level_high = level;
        r.edge_count = edges;
        r.speed      = speed_now;
        r.min_seen   = lo_seen;
        r.max_seen   = hi_seen;
        return r;
    endfunction

    task automatic compare_field(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t got;
        reading_t want;
        if (!rst_n)
        begin
            poll_ms        = POLL_INTERVAL_RST;
            conv           = STEPS_CONV_RST;
            hi_seen        = '0;
            lo_seen        = '1;
            midpoint       = SAMPLE_BITS_DEF'(SAMPLE_MID);
            hyst           = SAMPLE_BITS_DEF'(SAMPLE_MID / 4);
            level          = 1'b0;
            edges          = '0;
            last_poll_ms   = '0;
            speed_now      = '0;
            mismatch_count = 0;
            checked        = 0;
            update_count   = 0;
            edge_total     = 0;
            readings_due.delete();
        end
        else
        begin
            // results first, so a result never meets its own transaction
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{level_high: out_ch.level_high, rising_edge: out_ch.rising_edge,
                        edge_count: out_ch.edge_count, speed: out_ch.speed,
                        speed_updated: out_ch.speed_updated, min_seen: out_ch.min_seen,
                        max_seen: out_ch.max_seen};
                if (readings_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: result with nothing expected, count %0d speed %0d",
                             $time, got.edge_count, got.speed);
                end
                else
                begin
                    want = readings_due.pop_front();
                    compare_field("level_high", want.level_high, got.level_high);
                    compare_field("rising_edge", want.rising_edge, got.rising_edge);
                    compare_field("edge_count", want.edge_count, got.edge_count);
                    compare_field("speed", want.speed, got.speed);
                    compare_field("speed_updated", want.speed_updated, got.speed_updated);
                    compare_field("min_seen", want.min_seen, got.min_seen);
                    compare_field("max_seen", want.max_seen, got.max_seen);
                    checked++;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_POLL_INTERVAL)
                    poll_ms = cfg_data[POLL_W-1:0];
                else if (cfg_index == REG_STEPS_CONV)
                    conv = cfg_data[CONV_W-1:0];
            end
            if (in_ch.valid && in_ch.ready)
            begin
                want = step_encoder(func_e'(in_ch.func), in_ch.sample, in_ch.timestamp);
                readings_due.push_back(want);
                if (want.speed_updated)
                    update_count++;
                if (want.rising_edge)
                    edge_total++;
            end
        end
        mismatches       <= mismatch_count;
        readings_checked <= checked;
        speed_updates    <= update_count;
        rising_edges     <= edge_total;
    end

endmodule

// ===== verif/tb_self_calibrating_encoder_speed_top.sv =====
`timescale 1ns / 1ps

module tb_self_calibrating_encoder_speed_top;

    import sces_pkg::*;
    import sces_tb_pkg::*;

    localparam int RESET_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT   = 2000;  // well above the long hold plus a slow item
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 40;    // quiet time after the last result
    localparam int PHASE_ITEMS      = 100;
    localparam int RANDOM_ITEMS     = 5 * PHASE_ITEMS;
    localparam int EDGE_PAIRS       = 8;     // full-swing edges sent back to back

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sces_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
    sces_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF), .COUNT_BITS(COUNT_BITS_DEF)) out_ch ();

    int mismatches;
    int readings_checked;
    int speed_updates;
    int rising_edges;

    // stimulus bookkeeping
    int              items_sent;
    logic [TS_W-1:0] now_ms;
    bit              src_gaps_on;

    // receiver control: random stalls and the one long hold
    bit sink_stalls_on;
    bit hold_request;
    bit hold_done;
    int sink_hold;

    // waveform generator state, shared across the random phases
    int wave_idx;
    bit wave_high;
    int wave_left;

    int quiet_cycles;

    self_calibrating_encoder_speed_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    sces_speed_check speed_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_ch            (in_ch),
        .out_ch           (out_ch),
        .mismatches       (mismatches),
        .readings_checked (readings_checked),
        .speed_updates    (speed_updates),
        .rising_edges     (rising_edges)
    );

    always #1 clk = ~clk;

    // receiver: short random stalls, plus one long hold so the block backs up
    // and has to stall its input while the sender keeps offering
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            sink_hold = LONG_HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold--;
            out_ch.ready <= 1'b0;
        end
        else if (sink_stalls_on && $urandom_range(0, 9) == 0)
        begin
            sink_hold = $urandom_range(0, 11);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // watchdog: any cycle with no transaction on either channel counts
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d of %0d results in",
                     WATCHDOG_LIMIT, readings_checked, items_sent);
            $display("tb_self_calibrating_encoder_speed_top: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one item and hold it until accepted; called and returns at a rising edge
    task automatic offer(func_e fn, logic [SAMPLE_BITS_DEF-1:0] s, logic [TS_W-1:0] ts);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= fn;
        in_ch.sample    <= s;
        in_ch.timestamp <= ts;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
    endtask

    // every item yields one result, so all results in means the block is idle
    task automatic wait_drained();
        while (readings_checked != items_sent)
            @(posedge clk);
    endtask

    // both registers in back-to-back cycles; the upper data bits of the
    // conversion write are junk that the block must drop
    task automatic write_config(logic [POLL_W-1:0] poll, logic [CONV_W-1:0] conv);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POLL_INTERVAL;
        cfg_data  <= poll;
        @(posedge clk);
        cfg_index <= REG_STEPS_CONV;
        cfg_data  <= {8'($urandom), conv};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // a square-ish wave around mid-scale whose swing grows over the random part,
    // so the calibration keeps widening; some noise inside the swing, some polls
    task automatic random_phase(logic [POLL_W-1:0] poll, logic [CONV_W-1:0] conv,
                                bit with_pressure);
        int    step_max;
        int    amp;
        int    value;
        int    pick;
        func_e fn;
        write_config(poll, conv);
        // roughly one speed recomputation every ten items
        step_max = int'(poll) / 5 + 2;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (with_pressure && n == 20)
                hold_request <= 1'b1;
            amp  = 8 + (wave_idx * 520) / RANDOM_ITEMS;
            pick = $urandom_range(0, 99);
            fn   = (pick < 80) ? FN_SAMPLE : FN_POLL;
            if (fn == FN_POLL)
                value = $urandom_range(0, SAMPLE_MAX);
            else if (pick < 8)
                value = SAMPLE_MID - amp + int'($urandom_range(0, 2 * amp));
            else
            begin
                if (wave_left == 0)
                begin
                    wave_high = !wave_high;
                    wave_left = $urandom_range(1, 4);
                end
                wave_left--;
                if (wave_high)
                    value = SAMPLE_MID + amp - int'($urandom_range(0, amp / 4));
                else
                    value = SAMPLE_MID - amp + int'($urandom_range(0, amp / 4));
            end
            if (value < 0)
                value = 0;
            if (value > SAMPLE_MAX)
                value = SAMPLE_MAX;
            // mostly forward steps, now and then a step back or a huge leap
            pick = $urandom_range(0, 49);
            if (pick == 0)
                now_ms = now_ms - $urandom_range(1, 1000);
            else if (pick == 1)
                now_ms = now_ms + $urandom();
            else
                now_ms = now_ms + $urandom_range(0, step_max);
            offer(fn, SAMPLE_BITS_DEF'(value), now_ms);
            wave_idx++;
        end
        in_ch.valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        // every block input known from time zero
        in_ch.valid     = 1'b0;
        in_ch.func      = FN_POLL;
        in_ch.sample    = '0;
        in_ch.timestamp = '0;
        cfg_we          = 1'b0;
        cfg_index       = REG_POLL_INTERVAL;
        cfg_data        = '0;
        src_gaps_on     = 1'b1;
        sink_stalls_on  = 1'b1;
        hold_request    = 1'b0;
        items_sent      = 0;
        now_ms          = '0;
        wave_idx        = 0;
        wave_high       = 1'b0;
        wave_left       = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, registers at their reset values
        // polls before any sample: calibration and trigger untouched, odd sample ignored
        offer(FN_POLL, SAMPLE_BITS_DEF'(SAMPLE_MAX), 32'd0);
        offer(FN_POLL, '0, 32'd100);
        // first sample collapses the range onto itself, then a narrow swing
        offer(FN_SAMPLE, 10'd512, 32'd120);
        offer(FN_SAMPLE, 10'd530, 32'd140);
        offer(FN_SAMPLE, 10'd490, 32'd160);
        offer(FN_SAMPLE, 10'd530, 32'd180);
        // inside the hysteresis band: level held
        offer(FN_SAMPLE, 10'd511, 32'd200);
        // interval passed: speed recomputed, count cleared
        offer(FN_POLL, '0, 32'd300);
        offer(FN_SAMPLE, 10'd470, 32'd310);
        offer(FN_SAMPLE, 10'd550, 32'd320);
        offer(FN_SAMPLE, 10'd470, 32'd330);
        offer(FN_SAMPLE, 10'd550, 32'd340);
        // elapsed exactly equal to the interval does not count, one more does
        offer(FN_POLL, '0, 32'd550);
        offer(FN_POLL, '0, 32'd551);
        // timestamp going backwards reads as a very long wait
        offer(FN_SAMPLE, 10'd500, 32'd200);
        offer(FN_POLL, '0, 32'hFFFF_FFFF);
        // wrap through zero, short elapsed time
        offer(FN_SAMPLE, 10'd560, 32'h0000_0005);
        offer(FN_SAMPLE, 10'd460, 32'h0000_0010);
        offer(FN_SAMPLE, 10'd560, 32'h0000_0020);
        offer(FN_POLL, '0, 32'h0000_0200);
        in_ch.valid <= 1'b0;
        wait_drained();
        now_ms = 32'h0000_0200;

        // random part, one register setting per phase, extremes among them
        random_phase(16'd1, 8'd255, 1'b0);
        random_phase(16'hFFFF, 8'd0, 1'b0);
        random_phase(POLL_W'($urandom_range(2, 3000)), CONV_W'($urandom), 1'b1);
        random_phase(POLL_INTERVAL_RST, STEPS_CONV_RST, 1'b0);
        random_phase(POLL_W'($urandom_range(1, 500)), 8'd255, 1'b0);

        // last part at full rate on both sides
        src_gaps_on = 1'b0;
        sink_stalls_on <= 1'b0;

        // a poll far enough ahead to force an update under any interval, then
        // full-scale edges back to back, all stamped with that same time so
        // the count builds up without a recomputation
        now_ms = now_ms + 32'd70000;
        offer(FN_POLL, '0, now_ms);
        for (int n = 0; n < EDGE_PAIRS; n++)
        begin
            offer(FN_SAMPLE, '0, now_ms);
            offer(FN_SAMPLE, SAMPLE_BITS_DEF'(SAMPLE_MAX), now_ms);
        end
        in_ch.valid <= 1'b0;
        wait_drained();

        // zero interval, largest scale: the built-up count over 1 ms, then one fresh edge over 2 ms
        write_config('0, 8'd255);
        offer(FN_POLL, '0, now_ms + 32'd1);
        offer(FN_SAMPLE, '0, now_ms + 32'd1);
        offer(FN_SAMPLE, SAMPLE_BITS_DEF'(SAMPLE_MAX), now_ms + 32'd1);
        offer(FN_POLL, '0, now_ms + 32'd3);
        in_ch.valid <= 1'b0;
        wait_drained();

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d input transactions (%0d random) over six register settings",
                 items_sent, RANDOM_ITEMS);
        $display("%0d results checked, %0d speed recomputations, %0d rising edges",
                 readings_checked, speed_updates, rising_edges);
        if (mismatches == 0 && readings_checked == items_sent)
            $display("tb_self_calibrating_encoder_speed_top: PASS");
        else
            $display("tb_self_calibrating_encoder_speed_top: FAIL");
        $finish;
    end

endmodule
